[rtl/core/soflf_pkg.sv]
// ----------------------------------------------------------------------------
// soflf_pkg: shared types and constants of the sof phase-lock loop filter
// Widths, scaling constants and the queue entry type used by all modules.
// ----------------------------------------------------------------------------
`default_nettype none

package soflf_pkg;

	localparam int unsigned IndexW   = 14;
	localparam int unsigned ElapsedW = 14;
	localparam int unsigned FrameW   = 11;
	localparam int unsigned PhaseW   = 12;
	localparam int unsigned OffsetW  = 9;
	localparam int unsigned NumW     = 30;
	localparam int unsigned AccW     = 32;

	// quarter-microsecond ticks of one 1 ms frame
	localparam int unsigned TicksPerFrame = 4000;

	localparam int unsigned ScaleMulW = 19;
	localparam logic [ScaleMulW-1:0] ScaleMul = 19'd349525;
	localparam int unsigned ScaleShift = 20;
	localparam int unsigned ProdW = ElapsedW + ScaleMulW;
	localparam int unsigned TickW = ProdW - ScaleShift;

	localparam logic [TickW-1:0] TickHalf  = TickW'(TicksPerFrame / 2);
	localparam logic [TickW-1:0] TickFrame = TickW'(TicksPerFrame);

	// lead = acc / 16, output = sum / 16384
	localparam int unsigned LeadShift  = 4;
	localparam int unsigned LeadW      = AccW - LeadShift;
	localparam int unsigned GainShift  = 12;
	localparam int unsigned FixedShift = 14;
	localparam int unsigned SumW       = LeadW + GainShift + 1;

	localparam int OffsetMax = 127;
	localparam int OffsetMin = -128;

	typedef struct packed {
		logic [FrameW-1:0] frame_number;
		logic [PhaseW-1:0] phase_error;
	} item_t;

endpackage

`default_nettype wire

[rtl/core/sof_phase_lock_loop_filter.sv]
// ----------------------------------------------------------------------------
// sof_phase_lock_loop_filter: sof-driven digital pll loop filter
// Front classifier and scaler, two-entry queue, pi filter back end.
// ----------------------------------------------------------------------------
// One beat per micro-frame event goes in, one beat comes out for each 1 ms
// frame (frame_index[2:0] == 0); other events are taken and dropped. The
// block accepts a beat every cycle while the queue is not full. A frame
// beat passes through the queue, the stage 1 register and the output
// register; the back end takes one every cycle unless the output is held.
// Then the two-entry queue holds up to two frame beats before input stalls.
`default_nettype none

module sof_phase_lock_loop_filter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [13:0] frame_index, [27:14] timer_elapsed, [31:28] zero
	input  wire logic [31:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [10:0] frame_number, [22:11] phase_error, [31:23] pll_offset,
	// [61:32] pll_num_word, [63:62] zero
	output logic [63:0]      m_tdata
);

	logic             q_full;
	logic             q_push;
	logic             q_pop;
	logic             q_not_empty;
	soflf_pkg::item_t q_item;
	soflf_pkg::item_t q_head;

	logic [soflf_pkg::FrameW-1:0]  frame_number;
	logic [soflf_pkg::PhaseW-1:0]  phase_error;
	logic [soflf_pkg::OffsetW-1:0] pll_offset;
	logic [soflf_pkg::NumW-1:0]    pll_num_word;

	soflf_front u_front (
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.frame_index   (s_tdata[13:0]),
		.timer_elapsed (s_tdata[27:14]),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_item        (q_item)
	);

	soflf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	soflf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.frame_number (frame_number),
		.phase_error  (phase_error),
		.pll_offset   (pll_offset),
		.pll_num_word (pll_num_word)
	);

	assign m_tdata = {2'b00, pll_num_word, pll_offset, phase_error, frame_number};

endmodule

`default_nettype wire

[rtl/core/soflf_front.sv]
// ----------------------------------------------------------------------------
// soflf_front: input classification and phase scaling
// Drops micro-frame beats, scales the timer count to ticks and wraps the phase.
// ----------------------------------------------------------------------------
`default_nettype none

module soflf_front (
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [soflf_pkg::IndexW-1:0]     frame_index,
	input  wire logic [soflf_pkg::ElapsedW-1:0]   timer_elapsed,
	input  wire logic                             q_full,
	output logic                                  q_push,
	output soflf_pkg::item_t                      q_item
);

	logic [soflf_pkg::ProdW-1:0] prod;
	logic [soflf_pkg::TickW-1:0] tick;
	logic [soflf_pkg::TickW-1:0] phase;

	assign s_tready = !q_full;

	// only whole 1 ms frames reach the filter
	assign q_push = s_tvalid && !q_full && (frame_index[2:0] == 3'd0);

	assign prod = soflf_pkg::ProdW'(timer_elapsed) * soflf_pkg::ProdW'(soflf_pkg::ScaleMul);
	assign tick = prod[soflf_pkg::ProdW-1:soflf_pkg::ScaleShift];

	always_comb begin
		if (tick >= soflf_pkg::TickHalf) begin
			phase = tick - soflf_pkg::TickFrame;
		end else begin
			phase = tick;
		end
	end

	assign q_item.frame_number = frame_index[soflf_pkg::IndexW-1:3];
	assign q_item.phase_error  = phase[soflf_pkg::PhaseW-1:0];

endmodule

`default_nettype wire

[rtl/core/soflf_queue.sv]
// ----------------------------------------------------------------------------
// soflf_queue: two-entry queue between front and back
// Registered storage; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module soflf_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  soflf_pkg::item_t       push_item,
	input  wire logic              pop,
	output logic                   full,
	output logic                   not_empty,
	output soflf_pkg::item_t       head
);

	soflf_pkg::item_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("queue push while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !not_empty)) else $error("queue pop while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

[rtl/core/soflf_back.sv]
// ----------------------------------------------------------------------------
// soflf_back: loop filter and output register
// Stage 1 updates the lead and integral accumulators, stage 2 forms the
// clipped, negated offset into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module soflf_back (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            q_not_empty,
	input  soflf_pkg::item_t                     q_head,
	output logic                                 q_pop,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [soflf_pkg::FrameW-1:0]         frame_number,
	output logic [soflf_pkg::PhaseW-1:0]         phase_error,
	output logic [soflf_pkg::OffsetW-1:0]        pll_offset,
	output logic [soflf_pkg::NumW-1:0]           pll_num_word
);

	localparam int unsigned AccW  = soflf_pkg::AccW;
	localparam int unsigned LeadW = soflf_pkg::LeadW;
	localparam int unsigned SumW  = soflf_pkg::SumW;
	localparam int unsigned PhW   = soflf_pkg::PhaseW;

	logic signed [AccW-1:0] lead_acc_q;
	logic signed [AccW-1:0] integ_acc_q;

	logic                    valid_s1;
	soflf_pkg::item_t        item_s1;
	logic                    pos_s1;
	logic                    neg_s1;
	logic signed [LeadW-1:0] lead_s1;
	logic signed [AccW-1:0]  integ_s1;

	logic load_s1;
	logic load_s2;

	logic signed [AccW-1:0]  phase_ext;
	logic signed [AccW-1:0]  acc_sum;
	logic signed [AccW:0]    lead_bias;
	logic signed [AccW:0]    lead_full;
	logic signed [LeadW-1:0] lead;

	logic signed [SumW-1:0]  sign_term;
	logic signed [SumW-1:0]  lead_term;
	logic signed [SumW-1:0]  integ_term;
	logic signed [SumW-1:0]  sum;
	logic signed [SumW-1:0]  sum_bias;
	logic signed [SumW-1:0]  filt_full;
	logic signed [7:0]       filt;
	logic signed [soflf_pkg::OffsetW-1:0] offset;

	assign load_s2 = !m_tvalid || m_tready;
	assign load_s1 = !valid_s1 || load_s2;
	assign q_pop   = q_not_empty && load_s1;

	// lead path: acc += phase, lead = acc / 16 toward zero, acc -= lead
	assign phase_ext = AccW'($signed(q_head.phase_error));
	assign acc_sum   = lead_acc_q + phase_ext;
	assign lead_bias = (AccW+1)'(acc_sum) + (acc_sum[AccW-1] ? (AccW+1)'(15) : '0);
	assign lead_full = lead_bias >>> soflf_pkg::LeadShift;
	assign lead      = lead_full[LeadW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_acc_q  <= '0;
			integ_acc_q <= '0;
			valid_s1    <= 1'b0;
		end else begin
			if (q_pop) begin
				lead_acc_q  <= acc_sum - AccW'(lead);
				integ_acc_q <= integ_acc_q + phase_ext;
			end
			if (load_s1) begin
				valid_s1 <= q_pop;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_s1  <= q_head;
			pos_s1   <= !q_head.phase_error[PhW-1] && (q_head.phase_error != '0);
			neg_s1   <= q_head.phase_error[PhW-1];
			lead_s1  <= lead;
			integ_s1 <= integ_acc_q;
		end
	end

	// output = (sign*4096 + lead*4096 + integral) / 16384 toward zero
	always_comb begin
		if (pos_s1) begin
			sign_term = SumW'(4096);
		end else if (neg_s1) begin
			sign_term = -SumW'(4096);
		end else begin
			sign_term = '0;
		end
	end

	assign lead_term  = $signed({lead_s1[LeadW-1], lead_s1, {soflf_pkg::GainShift{1'b0}}});
	assign integ_term = SumW'(integ_s1);
	assign sum        = sign_term + lead_term + integ_term;
	assign sum_bias   = sum + (sum[SumW-1] ? SumW'(16383) : '0);
	assign filt_full  = sum_bias >>> soflf_pkg::FixedShift;

	always_comb begin
		if (filt_full > SumW'(soflf_pkg::OffsetMax)) begin
			filt = 8'(soflf_pkg::OffsetMax);
		end else if (filt_full < SumW'(soflf_pkg::OffsetMin)) begin
			filt = 8'(soflf_pkg::OffsetMin);
		end else begin
			filt = filt_full[7:0];
		end
	end

	assign offset = -soflf_pkg::OffsetW'(filt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load_s2) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			frame_number <= item_s1.frame_number;
			phase_error  <= item_s1.phase_error;
			pll_offset   <= offset;
			pll_num_word <= soflf_pkg::NumW'(offset);
		end
	end

`ifndef SYNTHESIS
	a_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(pll_offset) >= -9'sd127))
		else $error("pll offset below range");
	a_num_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (pll_num_word == soflf_pkg::NumW'($signed(pll_offset))))
		else $error("numerator word does not match offset");
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(phase_error) >= -12'sd2000))
		else $error("phase below range");
`endif

endmodule

`default_nettype wire

[tb/sof_pll_filter_checker.sv]
// ----------------------------------------------------------------------------
// sof_pll_filter_checker: scoreboard for the sof phase-lock loop filter
// Watches both stream channels, predicts the loop filter output for every
// accepted 1 ms frame beat and compares each result beat field by field.
// ----------------------------------------------------------------------------
module sof_pll_filter_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	// [13:0] frame_index, [27:14] timer_elapsed, [31:28] zero
	input  wire logic [31:0] s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	// [10:0] frame_number, [22:11] phase_error, [31:23] pll_offset,
	// [61:32] pll_num_word, [63:62] zero
	input  wire logic [63:0] m_tdata,
	output int               fail_count,
	output int               pending,
	output int               checked
);

	localparam longint FrameTicks = longint'(soflf_pkg::TicksPerFrame);

	typedef struct packed {
		logic [soflf_pkg::FrameW-1:0]  frame_number;
		logic [soflf_pkg::PhaseW-1:0]  phase_error;
		logic [soflf_pkg::OffsetW-1:0] pll_offset;
		logic [soflf_pkg::NumW-1:0]    pll_num_word;
	} loop_result_t;

	logic [soflf_pkg::AccW-1:0] lead_acc;
	logic [soflf_pkg::AccW-1:0] integ_acc;
	loop_result_t    loop_results_q[$];
	loop_result_t    want;

	function automatic loop_result_t advance_loop_filter(
			input logic [soflf_pkg::IndexW-1:0] idx,
			input logic [soflf_pkg::ElapsedW-1:0] elapsed);
		loop_result_t r;
		longint prod;
		longint phase;
		longint lead;
		longint sgn;
		longint total;
		longint filt;
		logic [31:0] ofs32;
		prod = longint'(elapsed) * 64'd349525;
		phase = prod >> 20;
		if (phase >= FrameTicks / 2)
			phase = phase - FrameTicks;
		// lead path: one-pole low-pass, divide by 16 toward zero
		lead_acc = lead_acc + phase[31:0];
		lead = longint'($signed(lead_acc)) / 16;
		lead_acc = lead_acc - lead[31:0];
		sgn = (phase > 0) ? 1 : ((phase < 0) ? -1 : 0);
		total = sgn * 4096 + lead * 4096 + longint'($signed(integ_acc));
		filt = total / 16384;
		integ_acc = integ_acc + phase[31:0];
		if (filt > soflf_pkg::OffsetMax)
			filt = soflf_pkg::OffsetMax;
		else if (filt < soflf_pkg::OffsetMin)
			filt = soflf_pkg::OffsetMin;
		filt = -filt;
		ofs32 = filt[31:0];
		r.frame_number = idx[soflf_pkg::IndexW-1:3];
		r.phase_error = phase[soflf_pkg::PhaseW-1:0];
		r.pll_offset = filt[soflf_pkg::OffsetW-1:0];
		r.pll_num_word = ofs32[soflf_pkg::NumW-1:0];
		return r;
	endfunction

	function automatic void check_field(input string name, input longint exp_v,
			input longint got_v);
		if (exp_v != got_v) begin
			$error("%s: expected %0d, actual %0d", name, exp_v, got_v);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			lead_acc = '0;
			integ_acc = '0;
			loop_results_q.delete();
			fail_count = 0;
			checked = 0;
			pending = 0;
		end else begin
			// micro-frame beats leave the filter state alone
			if (s_tvalid && s_tready && s_tdata[2:0] == 3'b000)
				loop_results_q.push_back(advance_loop_filter(s_tdata[13:0], s_tdata[27:14]));
			if (m_tvalid && m_tready) begin
				if (loop_results_q.size() == 0) begin
					$error("result beat with no frame beat waiting: data %h", m_tdata);
					fail_count++;
				end else begin
					want = loop_results_q.pop_front();
					check_field("frame_number", want.frame_number, m_tdata[10:0]);
					check_field("phase_error", $signed(want.phase_error),
						$signed(m_tdata[22:11]));
					check_field("pll_offset", $signed(want.pll_offset),
						$signed(m_tdata[31:23]));
					check_field("pll_num_word", want.pll_num_word, m_tdata[61:32]);
					checked++;
				end
			end
			pending = loop_results_q.size();
		end
	end

endmodule

[tb/tb_sof_phase_lock_loop_filter.sv]
// ----------------------------------------------------------------------------
// tb_sof_phase_lock_loop_filter: stimulus and verdict for the loop filter
// Drives micro-frame event beats (directed corners, frame runs with steady
// phase, noise) under several idle/stall mixes. Checking is done by
// sof_pll_filter_checker.
// ----------------------------------------------------------------------------
module tb_sof_phase_lock_loop_filter;

	localparam int CycleLimit = 100000;
	localparam int BeatsPerPhase = 382;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;

	int fail_count;
	int pending;
	int checked;
	int gap_pct = 0;
	int stall_pct = 0;
	int beats_sent = 0;
	int frame_beats = 0;
	int beat_goal = 0;
	int cycle_count = 0;

	sof_phase_lock_loop_filter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	sof_pll_filter_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic push_event(input logic [13:0] idx, input logic [13:0] elapsed);
		while ($urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0000, elapsed, idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		beats_sent++;
		if (idx[2:0] == 3'b000)
			frame_beats++;
	endtask

	// consecutive 1 ms frames with a steady phase, micro-frames in between
	task automatic send_frame_run(input int frames);
		logic [13:0] idx;
		int base;
		int e;
		bit sparse;
		idx = {11'($urandom_range(0, 2047)), 3'b000};
		sparse = ($urandom_range(0, 99) < 20);
		case ($urandom_range(0, 3))
			0: base = $urandom_range(0, 400);
			1: base = $urandom_range(11600, 11999);
			2: base = $urandom_range(0, 11999);
			default: base = $urandom_range(0, 16383);
		endcase
		repeat (frames) begin
			if (beats_sent >= beat_goal)
				return;
			e = base + $urandom_range(0, 40) - 20;
			if (e < 0)
				e = 0;
			if (e > 16383)
				e = 16383;
			push_event(idx, 14'(e));
			for (int m = 1; m < 8; m++) begin
				if (!sparse || $urandom_range(0, 99) < 30)
					push_event(idx + 14'(m), 14'($urandom_range(0, 11999)));
			end
			idx = idx + 14'd8;
		end
	endtask

	task automatic run_phase(input int gap, input int stall, input int goal);
		gap_pct = gap;
		stall_pct = stall;
		beat_goal = beats_sent + goal;
		while (beats_sent < beat_goal) begin
			if ($urandom_range(0, 99) < 80)
				send_frame_run($urandom_range(3, 40));
			else
				repeat ($urandom_range(1, 6))
					push_event(14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383)));
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners
		push_event(14'd0, 14'd0);
		push_event(14'h3fff, 14'h3fff);
		push_event(14'h3ff8, 14'h3fff);
		push_event(14'd8, 14'd11999);
		push_event(14'd16, 14'd12003);
		push_event(14'd24, 14'd6000);
		push_event(14'd32, 14'd6001);
		for (int m = 1; m < 8; m++)
			push_event(14'd32 + 14'(m), 14'($urandom_range(0, 16383)));
		push_event(14'd40, 14'd3);
		push_event(14'd48, 14'd4);
		push_event(14'h2aa8, 14'h2aaa);
		push_event(14'h1550, 14'h1555);
		push_event(14'h0ff0, 14'd11998);

		run_phase(0, 0, BeatsPerPhase);
		run_phase(46, 0, BeatsPerPhase);
		run_phase(0, 46, BeatsPerPhase);
		run_phase(13, 13, BeatsPerPhase);

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("sent %0d event beats (%0d frame beats), compared %0d results", beats_sent,
			frame_beats, checked);
		$display("covered corner counts, steady-phase frame runs and idle/stall mixes");
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[sim.f]
rtl/core/soflf_pkg.sv
rtl/core/soflf_front.sv
rtl/core/soflf_queue.sv
rtl/core/soflf_back.sv
rtl/core/sof_phase_lock_loop_filter.sv
tb/sof_pll_filter_checker.sv
tb/tb_sof_phase_lock_loop_filter.sv
